[rtl/anp_pkg.sv]
// Package for the ASCII unsigned number parser: widths, character codes,
// the parse phase type and the structs passed between its modules.
// No dependencies.
`default_nettype none

package anp_pkg;

	// Width of the running value and of the number_value result field.
	localparam int VALUE_W = 32;
	localparam int NUM_W   = 32;
	// Extra head room for the times-ten-plus-digit sum.
	localparam int DEC_W   = VALUE_W + 4;
	localparam int DIGIT_W = 4;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_X  = 8'h78;

	// Letters a-f and A-F carry their value minus nine in the low nibble.
	localparam logic [DIGIT_W-1:0] LETTER_OFS = 4'd9;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_ZERO,
		PH_HEXSTART,
		PH_HEXDIG,
		PH_DECDIG,
		PH_TRAIL,
		PH_FAIL
	} phase_t;

	// Classification of one character.
	typedef struct packed {
		logic               is_nul;
		logic               is_blank;
		logic               is_zero;
		logic               is_x;
		logic               is_dec;
		logic               is_hex;
		logic [DIGIT_W-1:0] digit;
	} char_class_t;

	// One parse result.
	typedef struct packed {
		logic             valid_number;
		logic [NUM_W-1:0] number_value;
		logic             wrapped;
	} result_t;

endpackage

`default_nettype wire

[rtl/anp_classify.sv]
// Character classifier: decodes one byte into blank, digit and prefix flags
// and its digit value. Depends on anp_pkg.
`default_nettype none

module anp_classify
	import anp_pkg::*;
(
	input  wire logic [7:0]  char_code,
	output char_class_t      cls
);

	logic is_upper;
	logic is_lower;

	// Letter ranges for hexadecimal digits.
	assign is_upper = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
	assign is_lower = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);

	// Flags and digit value.
	always_comb begin
		cls.is_nul   = (char_code == CH_NUL);
		cls.is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
		cls.is_zero  = (char_code == CH_ZERO);
		cls.is_x     = (char_code == CH_LO_X) || (char_code == CH_UP_X);
		cls.is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		cls.is_hex   = cls.is_dec || is_upper || is_lower;
		if (cls.is_dec) begin
			cls.digit = char_code[DIGIT_W-1:0];
		end else begin
			cls.digit = char_code[DIGIT_W-1:0] + LETTER_OFS;
		end
	end

endmodule

`default_nettype wire

[rtl/anp_step.sv]
// Parse state machine and value accumulator: applies one classified
// character per advance and forms the result on the terminating NUL.
// Depends on anp_pkg.
`default_nettype none

module anp_step
	import anp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire char_class_t cls,
	input  wire logic        hex_en,
	output result_t          res
);

	phase_t               phase_q;
	phase_t               phase_d;
	logic [VALUE_W-1:0]   acc_q;
	logic [VALUE_W-1:0]   acc_d;
	logic                 ovf_q;
	logic                 ovf_d;
	logic                 add_dec;
	logic                 add_hex;
	logic [DEC_W-1:0]     dec_sum;
	logic                 ok;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_LEAD: begin
				if (cls.is_blank) begin
					phase_d = PH_LEAD;
				end else if (cls.is_zero) begin
					phase_d = PH_ZERO;
				end else if (cls.is_dec) begin
					phase_d = PH_DECDIG;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_ZERO: begin
				if (cls.is_x && hex_en) begin
					phase_d = PH_HEXSTART;
				end else if (cls.is_dec) begin
					phase_d = PH_DECDIG;
				end else if (cls.is_blank) begin
					phase_d = PH_TRAIL;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_HEXSTART: begin
				phase_d = cls.is_hex ? PH_HEXDIG : PH_FAIL;
			end
			PH_HEXDIG: begin
				if (cls.is_hex) begin
					phase_d = PH_HEXDIG;
				end else if (cls.is_blank) begin
					phase_d = PH_TRAIL;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_DECDIG: begin
				if (cls.is_dec) begin
					phase_d = PH_DECDIG;
				end else if (cls.is_blank) begin
					phase_d = PH_TRAIL;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_TRAIL: begin
				phase_d = cls.is_blank ? PH_TRAIL : PH_FAIL;
			end
			default: begin
				phase_d = PH_FAIL;
			end
		endcase
	end

	// Accumulate controls for the current phase and character.
	always_comb begin
		add_dec = 1'b0;
		add_hex = 1'b0;
		case (phase_q)
			PH_LEAD:     add_dec = cls.is_dec && !cls.is_zero;
			PH_ZERO:     add_dec = cls.is_dec && !(cls.is_x && hex_en);
			PH_DECDIG:   add_dec = cls.is_dec;
			PH_HEXSTART: add_hex = cls.is_hex;
			PH_HEXDIG:   add_hex = cls.is_hex;
			default: begin
				add_dec = 1'b0;
				add_hex = 1'b0;
			end
		endcase
	end

	// Times ten plus digit, with head room to see the wrap.
	assign dec_sum = ({{(DEC_W-VALUE_W){1'b0}}, acc_q} << 3)
		+ ({{(DEC_W-VALUE_W){1'b0}}, acc_q} << 1)
		+ {{(DEC_W-DIGIT_W){1'b0}}, cls.digit};

	// Value and wrap flag update.
	always_comb begin
		acc_d = acc_q;
		ovf_d = ovf_q;
		if (add_dec) begin
			acc_d = dec_sum[VALUE_W-1:0];
			ovf_d = ovf_q || (dec_sum[DEC_W-1:VALUE_W] != '0);
		end else if (add_hex) begin
			acc_d = {acc_q[VALUE_W-DIGIT_W-1:0], cls.digit};
			ovf_d = ovf_q || (acc_q[VALUE_W-1:VALUE_W-DIGIT_W] != '0);
		end
	end

	// Result on the terminating NUL.
	assign ok = (phase_q == PH_ZERO) || (phase_q == PH_DECDIG) ||
		(phase_q == PH_HEXDIG) || (phase_q == PH_TRAIL);

	always_comb begin
		res.valid_number = ok;
		res.number_value = ok ? NUM_W'(acc_q) : '0;
		res.wrapped      = ok && ovf_q;
	end

	// State registers; a NUL returns everything to the start of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			if (cls.is_nul) begin
				phase_q <= PH_LEAD;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
			end
		end
	end

	// A terminated string leaves a clean parse state behind.
	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cls.is_nul |=> phase_q == PH_LEAD && acc_q == '0 && !ovf_q)
		else $error("parse state not cleared after NUL");

	// The wrap flag is only set once digits have been taken.
	a_ovf_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (phase_q == PH_DECDIG || phase_q == PH_HEXDIG ||
			phase_q == PH_TRAIL || phase_q == PH_FAIL))
		else $error("wrap flag set before any digit");

	// Nothing accumulates while still skipping leading blanks.
	a_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEAD |-> acc_q == '0)
		else $error("value nonzero in leading phase");

endmodule

`default_nettype wire

[rtl/ascii_unsigned_number_parser_unit.sv]
// A character transfer is registered in the input stage, then applied to the parse
// state; a NUL's result is registered in the result register once the slot is free.
// Throughput: one character per cycle, set by the parse step; input stalls only
// while a NUL waits behind an untaken result.
// Reset (arst_n low, asynchronous): both stages empty, parse state at leading
// blanks with a zero value, hex prefix enabled.
// Top level of the ASCII unsigned number parser; depends on anp_pkg,
// anp_classify and anp_step.
`default_nettype none

module ascii_unsigned_number_parser_unit
	import anp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       char_code,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  valid_number,
	output logic [NUM_W-1:0]      number_value,
	output logic                  wrapped,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             hex_prefix_enable
);

	logic        char_valid_s1;
	logic [7:0]  char_s1;
	logic        hex_en_q;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res;
	char_class_t cls;
	logic        out_free;
	logic        advance;

	// Configuration register is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_en_q <= 1'b1;
		end else if (cfg_valid) begin
			hex_en_q <= hex_prefix_enable;
		end
	end

	// Flow control: non-NUL characters always advance, a NUL needs the
	// result slot.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = char_valid_s1 && (!cls.is_nul || out_free);
	assign in_ready = !char_valid_s1 || advance;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			char_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	anp_classify u_classify (
		.char_code (char_s1),
		.cls       (cls)
	);

	anp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cls     (cls),
		.hex_en  (hex_en_q),
		.res     (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && cls.is_nul;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cls.is_nul) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign valid_number = res_q.valid_number;
	assign number_value = res_q.number_value;
	assign wrapped      = res_q.wrapped;

	// A NUL never overwrites a result that is still waiting.
	a_nul_stall: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid_s1 && cls.is_nul && out_valid_q && !out_ready |-> !in_ready)
		else $error("NUL accepted over a pending result");

	// An invalid result carries zero value and no wrap.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !valid_number |-> number_value == '0 && !wrapped)
		else $error("invalid result with nonzero fields");

	// A result appears only after a NUL was processed.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && cls.is_nul))
		else $error("result without terminating NUL");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ascii_unsigned_number_parser_unit: directed strings, then
// random strings under several handshake pacing mixes, checked against a local parser model.
// Depends on anp_pkg and the parser RTL.

module tb;
	import anp_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int RAND_CHARS   = 150;
	localparam longint WATCHDOG_NS = 5_000_000;
	localparam result_t NO_NUMBER = '{1'b0, 32'd0, 1'b0};

	// One directed string. A nonzero split writes the opposite hex enable after that
	// many characters. Fixed rows carry their result by hand.
	typedef struct {
		bit      hex;
		string   text;
		int      split;
		bit      fixed;
		result_t res;
	} probe_row_t;

	probe_row_t probes[24] = '{
		'{1'b1, "",                     0, 1'b1, NO_NUMBER},
		'{1'b1, " \t ",                 0, 1'b1, NO_NUMBER},
		'{1'b1, "0",                    0, 1'b1, '{1'b1, 32'd0, 1'b0}},
		'{1'b1, "4294967295",           0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
		'{1'b1, "4294967296",           0, 1'b1, '{1'b1, 32'd0, 1'b1}},
		'{1'b1, "0xFFFFFFFF",           0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
		'{1'b1, "0x100000000",          0, 1'b1, '{1'b1, 32'd0, 1'b1}},
		'{1'b1, "0x",                   0, 1'b1, NO_NUMBER},
		'{1'b1, "0X \t",                0, 1'b1, NO_NUMBER},
		'{1'b1, "  0xdeadBEEF\t ",      0, 1'b0, NO_NUMBER},
		'{1'b1, "007",                  0, 1'b0, NO_NUMBER},
		'{1'b1, "\t0 ",                 0, 1'b0, NO_NUMBER},
		'{1'b1, "12a",                  0, 1'b1, NO_NUMBER},
		'{1'b1, "1 2",                  0, 1'b1, NO_NUMBER},
		'{1'b1, "\377",                 0, 1'b1, NO_NUMBER},
		'{1'b1, "9\200 ",               0, 1'b1, NO_NUMBER},
		'{1'b1, "x1",                   0, 1'b1, NO_NUMBER},
		'{1'b1, "0xg",                  0, 1'b1, NO_NUMBER},
		'{1'b1, "99999999999999999999", 0, 1'b0, NO_NUMBER},
		'{1'b1, "0x5",                  1, 1'b1, NO_NUMBER},
		'{1'b0, "0x5",                  1, 1'b1, '{1'b1, 32'd5, 1'b0}},
		'{1'b0, "0x1f",                 0, 1'b1, NO_NUMBER},
		'{1'b0, "0Xa",                  0, 1'b1, NO_NUMBER},
		'{1'b0, "\t123\t",              0, 1'b0, NO_NUMBER}
	};

	int idle_sched[4]  = '{0, 60, 0, 18};
	int stall_sched[4] = '{0, 0, 60, 18};

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       char_code;
	logic             out_valid;
	logic             out_ready;
	logic             valid_number;
	logic [NUM_W-1:0] number_value;
	logic             wrapped;
	logic             cfg_valid;
	logic             cfg_ready;
	logic             hex_prefix_enable;

	// Local copy of the parser state and its register.
	phase_t      parse_ph;
	logic [31:0] value_acc;
	logic        value_wrapped;
	logic        hex_on;

	result_t     pending_results[$];
	logic [7:0]  text_buf[$];
	bit          fixed_on;
	result_t     fixed_res;

	int idle_pct;
	int stall_pct;
	bit hold_req;
	int mismatches;
	int results_seen;
	int chars_sent;

	ascii_unsigned_number_parser_unit DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.char_code         (char_code),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.valid_number      (valid_number),
		.number_value      (number_value),
		.wrapped           (wrapped),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.hex_prefix_enable (hex_prefix_enable)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Advance the parser state by one character; a NUL queues the string's result.
	function automatic void parse_char(input logic [7:0] c);
		logic        blank;
		logic        dec;
		logic        hexdig;
		logic [3:0]  nib;
		logic [35:0] dec_sum;
		result_t     r;
		blank  = (c == CH_SPACE) || (c == CH_TAB);
		dec    = (c >= CH_ZERO) && (c <= CH_NINE);
		hexdig = dec || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
		// Letters keep their value minus nine in the low nibble.
		nib    = dec ? c[3:0] : c[3:0] + 4'd9;
		dec_sum = {4'd0, value_acc} * 36'd10 + {32'd0, c[3:0]};

		if (c == CH_NUL) begin
			r.valid_number = (parse_ph == PH_ZERO) || (parse_ph == PH_DECDIG) ||
				(parse_ph == PH_HEXDIG) || (parse_ph == PH_TRAIL);
			r.number_value = r.valid_number ? value_acc : 32'd0;
			r.wrapped      = r.valid_number ? value_wrapped : 1'b0;
			pending_results.push_back(fixed_on ? fixed_res : r);
			parse_ph      = PH_LEAD;
			value_acc     = 32'd0;
			value_wrapped = 1'b0;
			return;
		end

		case (parse_ph)
			PH_LEAD: begin
				if (c == CH_ZERO) begin
					parse_ph = PH_ZERO;
				end else if (dec) begin
					value_acc = dec_sum[31:0];
					parse_ph  = PH_DECDIG;
				end else if (!blank) begin
					parse_ph = PH_FAIL;
				end
			end
			PH_ZERO: begin
				if ((c == CH_LO_X || c == CH_UP_X) && hex_on) begin
					parse_ph = PH_HEXSTART;
				end else if (dec) begin
					value_acc = dec_sum[31:0];
					parse_ph  = PH_DECDIG;
				end else begin
					parse_ph = blank ? PH_TRAIL : PH_FAIL;
				end
			end
			PH_HEXSTART, PH_HEXDIG: begin
				if (hexdig) begin
					if (value_acc[31:28] != 4'd0)
						value_wrapped = 1'b1;
					value_acc = {value_acc[27:0], nib};
					parse_ph  = PH_HEXDIG;
				end else begin
					parse_ph = (blank && parse_ph == PH_HEXDIG) ? PH_TRAIL : PH_FAIL;
				end
			end
			PH_DECDIG: begin
				if (dec) begin
					if (dec_sum[35:32] != 4'd0)
						value_wrapped = 1'b1;
					value_acc = dec_sum[31:0];
				end else begin
					parse_ph = blank ? PH_TRAIL : PH_FAIL;
				end
			end
			PH_TRAIL: begin
				if (!blank)
					parse_ph = PH_FAIL;
			end
			default: begin
				parse_ph = PH_FAIL;
			end
		endcase
	endfunction

	// Build one random string, mostly well formed, ending in NUL.
	function automatic void make_text(ref logic [7:0] txt[$]);
		int kind;
		int d;
		txt.delete();
		repeat ($urandom_range(2)) txt.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
		kind = $urandom_range(99);
		if (kind < 45) begin
			if ($urandom_range(3) == 0)
				txt.push_back(CH_ZERO);
			repeat ($urandom_range(1, 11)) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
		end else if (kind < 85) begin
			txt.push_back(CH_ZERO);
			txt.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
			// Zero digits here gives a bare prefix.
			repeat ($urandom_range(9)) begin
				d = $urandom_range(15);
				if (d < 10)
					txt.push_back(8'(CH_ZERO + d));
				else
					txt.push_back(8'(($urandom_range(1) ? CH_LO_A : CH_UP_A) + d - 10));
			end
		end else begin
			repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(1, 255)));
		end
		repeat ($urandom_range(2)) txt.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
		// Occasionally break a good string with a stray byte.
		if ($urandom_range(9) == 0 && txt.size() != 0)
			txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(1, 255));
		txt.push_back(CH_NUL);
	endfunction

	// Offer one character and wait for its transfer.
	task automatic send_char(input logic [7:0] c);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) >= idle_pct)
				break;
			in_valid <= 1'b0;
		end
		in_valid  <= 1'b1;
		char_code <= c;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		parse_char(c);
		chars_sent++;
	endtask

	// Stop offering, then wait for every result plus the pipeline depth.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_hex(input logic v);
		wait_idle();
		@(negedge clk);
		cfg_valid         <= 1'b1;
		hex_prefix_enable <= v;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		hex_on = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stalls, and one long hold-off on request.
	initial begin : result_sink
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare every result transfer with the oldest queued result.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result valid_number=%b number_value=%h wrapped=%b",
					$time, valid_number, number_value, wrapped);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (valid_number !== want.valid_number) begin
					$display("%0t: valid_number expected %b, got %b",
						$time, want.valid_number, valid_number);
					mismatches++;
				end
				if (number_value !== want.number_value) begin
					$display("%0t: number_value expected %h, got %h",
						$time, want.number_value, number_value);
					mismatches++;
				end
				if (wrapped !== want.wrapped) begin
					$display("%0t: wrapped expected %b, got %b", $time, want.wrapped, wrapped);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("ascii_unsigned_number_parser_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		int i;
		int k;
		int start;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		char_code         = 8'd0;
		cfg_valid         = 1'b0;
		hex_prefix_enable = 1'b1;
		hold_req          = 1'b0;
		idle_pct          = 0;
		stall_pct         = 0;
		fixed_on          = 1'b0;
		fixed_res         = NO_NUMBER;
		mismatches        = 0;
		results_seen      = 0;
		chars_sent        = 0;
		parse_ph          = PH_LEAD;
		value_acc         = 32'd0;
		value_wrapped     = 1'b0;
		hex_on            = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed strings.
		for (i = 0; i < $size(probes); i++) begin
			if (probes[i].hex != hex_on)
				set_hex(probes[i].hex);
			fixed_on  = probes[i].fixed;
			fixed_res = probes[i].res;
			for (k = 0; k < probes[i].text.len(); k++) begin
				if (probes[i].split != 0 && k == probes[i].split)
					set_hex(!probes[i].hex);
				send_char(probes[i].text[k]);
			end
			send_char(CH_NUL);
		end
		wait_idle();
		fixed_on = 1'b0;

		// Random strings under each pacing mix.
		for (i = 0; i < 4; i++) begin
			set_hex(i == 1 ? 1'b0 : (i == 3 ? 1'($urandom_range(1)) : 1'b1));
			idle_pct  = idle_sched[i];
			stall_pct = stall_sched[i];
			// Fill the block by holding results back while characters keep coming.
			if (i == 0)
				hold_req = 1'b1;
			start = chars_sent;
			while (chars_sent - start < RAND_CHARS) begin
				make_text(text_buf);
				foreach (text_buf[k])
					send_char(text_buf[k]);
			end
		end
		wait_idle();

		$display("Checked %0d results over %0d characters: directed edge cases, then random",
			results_seen, chars_sent);
		$display("strings with hex prefix on and off under four pacing mixes and a long stall.");
		if (mismatches == 0)
			$display("ascii_unsigned_number_parser_unit regression: pass");
		else
			$display("ascii_unsigned_number_parser_unit regression: fail");
		$finish;
	end

endmodule
